// ===== sv/refract_direction_snell_defines.svh =====
// Assertion macros shared by the refraction pipeline.
`ifndef REFRACT_DIRECTION_SNELL_DEFINES_SVH
`define REFRACT_DIRECTION_SNELL_DEFINES_SVH

// same-cycle implication, checked outside reset
`define RDS_ASSERT_IMP(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define RDS_ASSERT_NXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== sv/rds_pkg.sv =====
// Shared types and constants of the refraction pipeline.
package rds_pkg;

    localparam int IN_W  = 16;
    localparam int OUT_W = 20;

    typedef logic signed [IN_W-1:0]  comp_t;
    typedef logic        [IN_W-1:0]  index_t;
    typedef logic signed [OUT_W-1:0] out_t;

    typedef struct packed {
        comp_t x;
        comp_t y;
        comp_t z;
    } vec_t;

    localparam out_t OUT_MAX = 20'sh7FFFF;
    localparam out_t OUT_MIN = -20'sh80000;

endpackage

// ===== sv/rds_div.sv =====
// Pipelined restoring divider for the index ratio, one quotient bit per stage.
module rds_div import rds_pkg::*; #(
    parameter int FRAC_BITS = 14
) (
    input  logic                      aclk,
    input  logic                      ce,
    input  index_t                    num_in,
    input  index_t                    den_in,
    output logic [IN_W+FRAC_BITS-1:0] quot_out
);

    localparam int NW = IN_W + FRAC_BITS;

    logic [IN_W-1:0] rem_reg  [NW];
    logic [NW-1:0]   quot_reg [NW];
    logic [NW-1:0]   num_reg  [NW];
    index_t          den_reg  [NW];

    genvar j;
    for (j = 0; j < NW; j++) begin : g_step
        logic [IN_W-1:0] rem_prev;
        logic [NW-1:0]   quot_prev;
        logic [NW-1:0]   num_prev;
        index_t          den_prev;
        logic [IN_W:0]   trial;
        logic            ge;
        logic [IN_W-1:0] rem_next;
        logic [NW-1:0]   quot_next;
        logic [NW-1:0]   num_next;

        if (j == 0) begin : g_first
            assign rem_prev  = '0;
            assign quot_prev = '0;
            assign num_prev  = {num_in, {FRAC_BITS{1'b0}}};
            assign den_prev  = den_in;
        end else begin : g_rest
            assign rem_prev  = rem_reg[j-1];
            assign quot_prev = quot_reg[j-1];
            assign num_prev  = num_reg[j-1];
            assign den_prev  = den_reg[j-1];
        end

        always_comb begin
            trial     = {rem_prev, num_prev[NW-1]};
            ge        = trial >= {1'b0, den_prev};
            rem_next  = ge ? IN_W'(trial - {1'b0, den_prev}) : trial[IN_W-1:0];
            quot_next = {quot_prev[NW-2:0], ge};
            num_next  = {num_prev[NW-2:0], 1'b0};
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                rem_reg[j]  <= rem_next;
                quot_reg[j] <= quot_next;
                num_reg[j]  <= num_next;
                den_reg[j]  <= den_prev;
            end
        end
    end

    assign quot_out = quot_reg[NW-1];

endmodule

// ===== sv/rds_sqrt.sv =====
// Pipelined integer square root, one root bit per stage.
module rds_sqrt import rds_pkg::*; #(
    parameter int FRAC_BITS = 14
) (
    input  logic                          aclk,
    input  logic                          ce,
    input  logic [2*(FRAC_BITS+7)-1:0]    rad_in,
    output logic [FRAC_BITS+7-1:0]        root_out
);

    localparam int SB = FRAC_BITS + 7;
    localparam int RW = 2 * SB;

    logic [SB+1:0] rem_reg  [SB];
    logic [SB-1:0] root_reg [SB];
    logic [RW-1:0] rad_reg  [SB];

    genvar j;
    for (j = 0; j < SB; j++) begin : g_step
        logic [SB+1:0] rem_prev;
        logic [SB-1:0] root_prev;
        logic [RW-1:0] rad_prev;
        logic [SB+3:0] trial;
        logic [SB+3:0] test;
        logic          ge;
        logic [SB+1:0] rem_next;
        logic [SB-1:0] root_next;
        logic [RW-1:0] rad_next;

        if (j == 0) begin : g_first
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign rad_prev  = rad_in;
        end else begin : g_rest
            assign rem_prev  = rem_reg[j-1];
            assign root_prev = root_reg[j-1];
            assign rad_prev  = rad_reg[j-1];
        end

        always_comb begin
            trial     = {rem_prev, rad_prev[RW-1:RW-2]};
            test      = {2'b00, root_prev, 2'b01};
            ge        = trial >= test;
            rem_next  = ge ? (SB+2)'(trial - test) : trial[SB+1:0];
            root_next = {root_prev[SB-2:0], ge};
            rad_next  = {rad_prev[RW-3:0], 2'b00};
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                rem_reg[j]  <= rem_next;
                root_reg[j] <= root_next;
                rad_reg[j]  <= rad_next;
            end
        end
    end

    assign root_out = root_reg[SB-1];

endmodule

// ===== sv/refract_direction_snell.sv =====
// Top level: pipelined Snell refraction of a fixed-point direction vector.
//
//  channel | ports                                   | transfer when
//  --------+-----------------------------------------+------------------------
//  input   | s_dir_*, s_norm_*, s_index_from/to      | s_valid && s_ready
//  result  | m_out_*, m_total_internal, m_bad_index  | m_valid && m_ready
//
// One ray per cycle sustained while the result is not stalled; the depth is
// set by the bit-per-stage ratio divider and the bit-per-stage square root.
// Synchronous active-low reset clears all valid bits; payload is not reset.
// A stalled result freezes the whole pipeline; s_ready = m_ready || !m_valid.
`include "refract_direction_snell_defines.svh"

module refract_direction_snell import rds_pkg::*; #(
    parameter int FRAC_BITS = 14
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   s_valid,
    output logic   s_ready,
    input  comp_t  s_dir_x,
    input  comp_t  s_dir_y,
    input  comp_t  s_dir_z,
    input  comp_t  s_norm_x,
    input  comp_t  s_norm_y,
    input  comp_t  s_norm_z,
    input  index_t s_index_from,
    input  index_t s_index_to,
    output logic   m_valid,
    input  logic   m_ready,
    output out_t   m_out_x,
    output out_t   m_out_y,
    output out_t   m_out_z,
    output logic   m_total_internal,
    output logic   m_bad_index
);

    localparam int F     = FRAC_BITS;
    localparam int NW    = IN_W + F;
    localparam int VW    = F + 13;
    localparam int KW    = F + 14;
    localparam int PW    = 2 * KW;
    localparam int SB    = F + 7;
    localparam int RW    = 2 * SB;
    localparam int DOT_W = 2 * IN_W + 2;

    localparam logic [PW-1:0] IMAX_P = (PW'(1) << (F + 12)) - PW'(1);
    localparam logic [PW-1:0] HALF_P = PW'(1) << (F - 1);
    localparam logic [NW-1:0] IMAX_N = (NW'(1) << (F + 12)) - NW'(1);
    localparam logic signed [VW-1:0] ONE_V = $signed(VW'(1) << F);

    typedef logic signed [VW-1:0]   val_t;
    typedef logic signed [2*VW-1:0] vprod_t;
    typedef logic signed [KW-1:0]   kval_t;
    typedef logic signed [PW-1:0]   kprod_t;

    typedef struct packed {
        vec_t d;
        vec_t n;
        logic bad;
    } div_side_t;

    typedef struct packed {
        val_t rc;
        val_t rd_x;
        val_t rd_y;
        val_t rd_z;
        vec_t n;
        logic bad;
        logic tir;
    } sq_side_t;

    function automatic val_t rnd_sat(input kprod_t p);
        logic [PW-1:0] mag;
        logic [PW-1:0] q;
        mag = p[PW-1] ? -p : p;
        q   = (mag + HALF_P) >> F;
        if (q > IMAX_P) begin
            q = IMAX_P;
        end
        return p[PW-1] ? -$signed(q[VW-1:0]) : $signed(q[VW-1:0]);
    endfunction

    function automatic vprod_t mul_v(input val_t a, input val_t b);
        return a * b;
    endfunction

    function automatic out_t sat_out(input logic signed [VW:0] v);
        if (v > (VW+1)'(OUT_MAX)) begin
            return OUT_MAX;
        end
        if (v < (VW+1)'(OUT_MIN)) begin
            return OUT_MIN;
        end
        return v[OUT_W-1:0];
    endfunction

    logic ce;
    assign ce      = m_ready || !m_valid;
    assign s_ready = ce;

    // ratio divider and matching side line
    logic [NW-1:0] quot;
    div_side_t     dv_side_reg  [NW];
    logic          dv_valid_reg [NW];
    div_side_t     dv_side_in;

    assign dv_side_in = '{d:   '{x: s_dir_x,  y: s_dir_y,  z: s_dir_z},
                          n:   '{x: s_norm_x, y: s_norm_y, z: s_norm_z},
                          bad: s_index_to == '0};

    rds_div #(.FRAC_BITS(F)) u_div (
        .aclk     (aclk),
        .ce       (ce),
        .num_in   (s_index_from),
        .den_in   (s_index_to),
        .quot_out (quot)
    );

    always_ff @(posedge aclk) begin
        if (ce) begin
            dv_side_reg[0] <= dv_side_in;
            for (int i = 1; i < NW; i++) begin
                dv_side_reg[i] <= dv_side_reg[i-1];
            end
        end
    end

    // stage registers
    logic                    a_valid_reg, b_valid_reg, c_valid_reg, e_valid_reg;
    logic                    g_valid_reg, h_valid_reg, j_valid_reg, k_valid_reg;
    div_side_t               a_side_reg, b_side_reg;
    val_t                    a_ratio_reg, b_ratio_reg;
    logic signed [DOT_W-1:0] a_dot_reg;
    val_t                    b_c1_reg;
    vprod_t                  c_cc_reg, c_rr_reg, c_rc_reg, c_rdx_reg, c_rdy_reg, c_rdz_reg;
    vec_t                    c_n_reg, e_n_reg, g_n_reg, h_n_reg, j_n_reg;
    logic                    c_bad_reg, e_bad_reg, g_bad_reg, h_bad_reg, j_bad_reg, k_bad_reg;
    val_t                    e_om_reg, e_rr_reg;
    val_t                    e_rc_reg, g_rc_reg, h_rc_reg;
    val_t                    e_rdx_reg, e_rdy_reg, e_rdz_reg;
    val_t                    g_rdx_reg, g_rdy_reg, g_rdz_reg;
    val_t                    h_rdx_reg, h_rdy_reg, h_rdz_reg;
    val_t                    j_rdx_reg, j_rdy_reg, j_rdz_reg;
    val_t                    k_rdx_reg, k_rdy_reg, k_rdz_reg;
    vprod_t                  g_sp_reg;
    logic [RW-1:0]           h_rad_reg;
    logic                    h_tir_reg, j_tir_reg, k_tir_reg;
    kval_t                   j_k_reg;
    kprod_t                  k_knx_reg, k_kny_reg, k_knz_reg;
    out_t                    m_out_x_reg, m_out_y_reg, m_out_z_reg;
    logic                    m_tir_reg, m_bad_reg, m_valid_reg;

    sq_side_t                sq_side_reg  [SB];
    logic                    sq_valid_reg [SB];
    logic [SB-1:0]           root;
    sq_side_t                sq_side_in;
    sq_side_t                sq_side_out;

    rds_sqrt #(.FRAC_BITS(F)) u_sqrt (
        .aclk     (aclk),
        .ce       (ce),
        .rad_in   (h_rad_reg),
        .root_out (root)
    );

    assign sq_side_in  = '{rc: h_rc_reg, rd_x: h_rdx_reg, rd_y: h_rdy_reg,
                           rd_z: h_rdz_reg, n: h_n_reg, bad: h_bad_reg, tir: h_tir_reg};
    assign sq_side_out = sq_side_reg[SB-1];

    // combinational next values
    logic signed [DOT_W-1:0] a_dot_next;
    val_t                    a_ratio_next;
    val_t                    b_c1_next;
    val_t                    e_cc_next;
    val_t                    h_sint2_next;
    logic signed [VW:0]      h_diff_next;
    logic                    h_tir_next;
    logic [RW-1:0]           h_rad_next;
    kval_t                   j_k_next;
    out_t                    m_out_x_next, m_out_y_next, m_out_z_next;
    logic                    m_zero_next;

    always_comb begin
        a_dot_next = DOT_W'(dv_side_reg[NW-1].d.x * dv_side_reg[NW-1].n.x)
                   + DOT_W'(dv_side_reg[NW-1].d.y * dv_side_reg[NW-1].n.y)
                   + DOT_W'(dv_side_reg[NW-1].d.z * dv_side_reg[NW-1].n.z);
        a_ratio_next = (quot > IMAX_N) ? $signed(IMAX_N[VW-1:0]) : $signed(quot[VW-1:0]);
        b_c1_next    = rnd_sat(-PW'(a_dot_reg));
        e_cc_next    = rnd_sat(PW'(c_cc_reg));
        h_sint2_next = rnd_sat(PW'(g_sp_reg));
        h_tir_next   = h_sint2_next > ONE_V;
        h_diff_next  = (VW+1)'(ONE_V) - (VW+1)'(h_sint2_next);
        h_rad_next   = h_tir_next ? '0 : (RW'($unsigned(h_diff_next)) << F);
        j_k_next     = KW'(sq_side_out.rc) - KW'($signed({1'b0, root}));
        m_zero_next  = k_bad_reg || k_tir_reg;
        m_out_x_next = m_zero_next ? '0
                     : sat_out((VW+1)'(k_rdx_reg) + (VW+1)'(rnd_sat(k_knx_reg)));
        m_out_y_next = m_zero_next ? '0
                     : sat_out((VW+1)'(k_rdy_reg) + (VW+1)'(rnd_sat(k_kny_reg)));
        m_out_z_next = m_zero_next ? '0
                     : sat_out((VW+1)'(k_rdz_reg) + (VW+1)'(rnd_sat(k_knz_reg)));
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NW; i++) begin
                dv_valid_reg[i] <= 1'b0;
            end
            for (int i = 0; i < SB; i++) begin
                sq_valid_reg[i] <= 1'b0;
            end
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            g_valid_reg <= 1'b0;
            h_valid_reg <= 1'b0;
            j_valid_reg <= 1'b0;
            k_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (ce) begin
            dv_valid_reg[0] <= s_valid;
            for (int i = 1; i < NW; i++) begin
                dv_valid_reg[i] <= dv_valid_reg[i-1];
            end
            a_valid_reg     <= dv_valid_reg[NW-1];
            b_valid_reg     <= a_valid_reg;
            c_valid_reg     <= b_valid_reg;
            e_valid_reg     <= c_valid_reg;
            g_valid_reg     <= e_valid_reg;
            h_valid_reg     <= g_valid_reg;
            sq_valid_reg[0] <= h_valid_reg;
            for (int i = 1; i < SB; i++) begin
                sq_valid_reg[i] <= sq_valid_reg[i-1];
            end
            j_valid_reg <= sq_valid_reg[SB-1];
            k_valid_reg <= j_valid_reg;
            m_valid_reg <= k_valid_reg;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (ce) begin
            a_side_reg  <= dv_side_reg[NW-1];
            a_ratio_reg <= a_ratio_next;
            a_dot_reg   <= a_dot_next;

            b_side_reg  <= a_side_reg;
            b_ratio_reg <= a_ratio_reg;
            b_c1_reg    <= b_c1_next;

            c_cc_reg  <= mul_v(b_c1_reg, b_c1_reg);
            c_rr_reg  <= mul_v(b_ratio_reg, b_ratio_reg);
            c_rc_reg  <= mul_v(b_ratio_reg, b_c1_reg);
            c_rdx_reg <= mul_v(b_ratio_reg, VW'(b_side_reg.d.x));
            c_rdy_reg <= mul_v(b_ratio_reg, VW'(b_side_reg.d.y));
            c_rdz_reg <= mul_v(b_ratio_reg, VW'(b_side_reg.d.z));
            c_n_reg   <= b_side_reg.n;
            c_bad_reg <= b_side_reg.bad;

            e_om_reg  <= ONE_V - e_cc_next;
            e_rr_reg  <= rnd_sat(PW'(c_rr_reg));
            e_rc_reg  <= rnd_sat(PW'(c_rc_reg));
            e_rdx_reg <= rnd_sat(PW'(c_rdx_reg));
            e_rdy_reg <= rnd_sat(PW'(c_rdy_reg));
            e_rdz_reg <= rnd_sat(PW'(c_rdz_reg));
            e_n_reg   <= c_n_reg;
            e_bad_reg <= c_bad_reg;

            g_sp_reg  <= mul_v(e_rr_reg, e_om_reg);
            g_rc_reg  <= e_rc_reg;
            g_rdx_reg <= e_rdx_reg;
            g_rdy_reg <= e_rdy_reg;
            g_rdz_reg <= e_rdz_reg;
            g_n_reg   <= e_n_reg;
            g_bad_reg <= e_bad_reg;

            h_rad_reg <= h_rad_next;
            h_tir_reg <= h_tir_next;
            h_rc_reg  <= g_rc_reg;
            h_rdx_reg <= g_rdx_reg;
            h_rdy_reg <= g_rdy_reg;
            h_rdz_reg <= g_rdz_reg;
            h_n_reg   <= g_n_reg;
            h_bad_reg <= g_bad_reg;

            sq_side_reg[0] <= sq_side_in;
            for (int i = 1; i < SB; i++) begin
                sq_side_reg[i] <= sq_side_reg[i-1];
            end

            j_k_reg   <= j_k_next;
            j_rdx_reg <= sq_side_out.rd_x;
            j_rdy_reg <= sq_side_out.rd_y;
            j_rdz_reg <= sq_side_out.rd_z;
            j_n_reg   <= sq_side_out.n;
            j_bad_reg <= sq_side_out.bad;
            j_tir_reg <= sq_side_out.tir;

            k_knx_reg <= j_k_reg * KW'(j_n_reg.x);
            k_kny_reg <= j_k_reg * KW'(j_n_reg.y);
            k_knz_reg <= j_k_reg * KW'(j_n_reg.z);
            k_rdx_reg <= j_rdx_reg;
            k_rdy_reg <= j_rdy_reg;
            k_rdz_reg <= j_rdz_reg;
            k_bad_reg <= j_bad_reg;
            k_tir_reg <= j_tir_reg;

            m_out_x_reg <= m_out_x_next;
            m_out_y_reg <= m_out_y_next;
            m_out_z_reg <= m_out_z_next;
            m_bad_reg   <= k_bad_reg;
            m_tir_reg   <= k_tir_reg && !k_bad_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_out_x          = m_out_x_reg;
    assign m_out_y          = m_out_y_reg;
    assign m_out_z          = m_out_z_reg;
    assign m_total_internal = m_tir_reg;
    assign m_bad_index      = m_bad_reg;

    `RDS_ASSERT_IMP(a_flags_excl, m_valid, !(m_total_internal && m_bad_index), "both flags set")
    `RDS_ASSERT_IMP(a_flag_zero, m_valid && (m_total_internal || m_bad_index), m_out_x == '0 && m_out_y == '0 && m_out_z == '0, "flagged result not zero")
    `RDS_ASSERT_IMP(a_stall_block, m_valid && !m_ready, !s_ready, "input taken while result stalled")
    `RDS_ASSERT_NXT(a_stall_hold, !s_ready, $stable(h_valid_reg) && $stable(j_valid_reg), "pipeline moved during stall")

endmodule

// ===== tb/refract_checker.sv =====
// Checker for the refraction pipeline: predicts each ray's result and compares transfers.
`timescale 1ns / 1ps

module refract_checker import rds_pkg::*; #(
    parameter int FRAC_BITS = 14
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   s_valid,
    input  logic   s_ready,
    input  comp_t  s_dir_x,
    input  comp_t  s_dir_y,
    input  comp_t  s_dir_z,
    input  comp_t  s_norm_x,
    input  comp_t  s_norm_y,
    input  comp_t  s_norm_z,
    input  index_t s_index_from,
    input  index_t s_index_to,
    input  logic   m_valid,
    input  logic   m_ready,
    input  out_t   m_out_x,
    input  out_t   m_out_y,
    input  out_t   m_out_z,
    input  logic   m_total_internal,
    input  logic   m_bad_index,
    output int     fail_count,
    output int     rays_pending
);

    localparam longint ONE  = longint'(1) << FRAC_BITS;
    localparam longint unsigned HALF = longint'(1) << (FRAC_BITS - 1);
    localparam longint unsigned IMAX = (longint'(1) << (FRAC_BITS + 12)) - 1;

    typedef struct {
        out_t x;
        out_t y;
        out_t z;
        logic tir;
        logic bad;
    } refracted_t;

    refracted_t expected_rays[$];

    function automatic longint clamp_mag(longint unsigned m, bit neg);
        if (m > IMAX)
            m = IMAX;
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint unsigned mag(longint v);
        return v < 0 ? longint'(0) - v : v;
    endfunction

    function automatic longint fx_mul(longint a, longint b);
        longint unsigned ua, ub;
        bit neg;
        ua = mag(a);
        ub = mag(b);
        neg = (a < 0) != (b < 0);
        if (ua != 0 && ub > (64'hFFFF_FFFF_FFFF_FFFF - HALF) / ua)
            return clamp_mag(IMAX, neg);
        return clamp_mag((ua * ub + HALF) >> FRAC_BITS, neg);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = longint'(1) << 62;
        while (b > v)
            b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic out_t clip_out(longint v);
        if (v > longint'(OUT_MAX))
            return OUT_MAX;
        if (v < longint'(OUT_MIN))
            return OUT_MIN;
        return out_t'(v);
    endfunction

    function automatic refracted_t refract(comp_t dx, comp_t dy, comp_t dz, comp_t nx,
                                           comp_t ny, comp_t nz, index_t n1, index_t n2);
        refracted_t r;
        longint d[3], n[3];
        longint dot, c1, om, ratio, sint2, cost, k;
        d = '{longint'(dx), longint'(dy), longint'(dz)};
        n = '{longint'(nx), longint'(ny), longint'(nz)};
        r = '{x: '0, y: '0, z: '0, tir: 1'b0, bad: 1'b0};
        if (n2 == 0) begin
            r.bad = 1'b1;
            return r;
        end
        dot = d[0] * n[0] + d[1] * n[1] + d[2] * n[2];
        c1 = clamp_mag((mag(-dot) + HALF) >> FRAC_BITS, -dot < 0);
        om = ONE - fx_mul(c1, c1);
        ratio = clamp_mag((longint'(n1) << FRAC_BITS) / longint'(n2), 1'b0);
        sint2 = fx_mul(fx_mul(ratio, ratio), om);
        if (sint2 > ONE) begin
            r.tir = 1'b1;
            return r;
        end
        cost = longint'(int_sqrt(longint'(ONE - sint2) << FRAC_BITS));
        k = fx_mul(ratio, c1) - cost;
        r.x = clip_out(fx_mul(ratio, d[0]) + fx_mul(k, n[0]));
        r.y = clip_out(fx_mul(ratio, d[1]) + fx_mul(k, n[1]));
        r.z = clip_out(fx_mul(ratio, d[2]) + fx_mul(k, n[2]));
        return r;
    endfunction

    assign rays_pending = expected_rays.size();

    always @(posedge aclk) begin
        refracted_t e;
        if (aresetn) begin
            if (s_valid && s_ready)
                expected_rays = {expected_rays,
                                 refract(s_dir_x, s_dir_y, s_dir_z, s_norm_x,
                                         s_norm_y, s_norm_z, s_index_from,
                                         s_index_to)};
            if (m_valid && m_ready) begin
                if (expected_rays.size() == 0) begin
                    $error("unexpected result transfer");
                    fail_count++;
                end else begin
                    e = expected_rays.pop_front();
                    if (m_out_x !== e.x) begin
                        $error("out_x expected %0d actual %0d", e.x, m_out_x);
                        fail_count++;
                    end
                    if (m_out_y !== e.y) begin
                        $error("out_y expected %0d actual %0d", e.y, m_out_y);
                        fail_count++;
                    end
                    if (m_out_z !== e.z) begin
                        $error("out_z expected %0d actual %0d", e.z, m_out_z);
                        fail_count++;
                    end
                    if (m_total_internal !== e.tir) begin
                        $error("total_internal expected %0d actual %0d", e.tir,
                               m_total_internal);
                        fail_count++;
                    end
                    if (m_bad_index !== e.bad) begin
                        $error("bad_index expected %0d actual %0d", e.bad, m_bad_index);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top: stimulus, result-side backpressure and verdict for the refraction pipeline.
`timescale 1ns / 1ps

module tb_top;
    import rds_pkg::*;

    logic   aclk = 1'b0;
    logic   aresetn = 1'b0;
    logic   s_valid = 1'b0;
    logic   s_ready;
    comp_t  s_dir_x = '0, s_dir_y = '0, s_dir_z = '0;
    comp_t  s_norm_x = '0, s_norm_y = '0, s_norm_z = '0;
    index_t s_index_from = '0, s_index_to = '0;
    logic   m_valid;
    logic   m_ready = 1'b0;
    out_t   m_out_x, m_out_y, m_out_z;
    logic   m_total_internal, m_bad_index;
    int     fail_count, rays_pending;
    bit     calm = 1'b0;
    bit     long_hold = 1'b0;

    always #10 aclk = ~aclk;

    refract_direction_snell uut (.*);
    refract_checker chk (.*);

    task automatic send_ray(comp_t dx, comp_t dy, comp_t dz, comp_t nx, comp_t ny,
                            comp_t nz, index_t n1, index_t n2);
        bit taken;
        s_valid      <= 1'b1;
        s_dir_x      <= dx;
        s_dir_y      <= dy;
        s_dir_z      <= dz;
        s_norm_x     <= nx;
        s_norm_y     <= ny;
        s_norm_z     <= nz;
        s_index_from <= n1;
        s_index_to   <= n2;
        do begin
            @(negedge aclk);
            taken = s_ready;
            @(posedge aclk);
        end while (!taken);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
    endtask

    function automatic comp_t unit_comp();
        return comp_t'($urandom_range(0, 32767) - 16384);
    endfunction

    function automatic comp_t any_comp();
        return comp_t'($urandom);
    endfunction

    // result-side backpressure
    initial begin
        @(posedge aresetn);
        forever begin
            if (long_hold) begin
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
                long_hold = 1'b0;
            end else if (calm || $urandom_range(0, 2) != 0) begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end else begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
            end
        end
    end

    initial begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        int cnt;
        index_t n1, n2;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: head-on, oblique, extremes, zero n2, total internal reflection
        send_ray(0, 0, -16384, 0, 0, 16384, 16384, 16384);
        send_ray(11585, 0, -11585, 0, 0, 16384, 16384, 24576);
        send_ray(11585, 0, -11585, 0, 0, 16384, 24576, 16384);
        send_ray(16000, 0, -3000, 0, 0, 16384, 24576, 16384);
        send_ray(16384, 0, 0, 0, 0, 16384, 16384, 0);
        send_ray(-32768, -32768, -32768, -32768, -32768, -32768, 65535, 0);
        send_ray(32767, 32767, 32767, 32767, 32767, 32767, 65535, 1);
        send_ray(-32768, -32768, -32768, 32767, 32767, 32767, 65535, 1);
        send_ray(32767, -32768, 32767, -32768, 32767, -32768, 0, 65535);
        send_ray(-32768, 32767, -32768, 32767, -32768, 32767, 65535, 65535);
        send_ray(0, 0, 0, 0, 0, 0, 0, 1);
        send_ray(0, 0, 0, 0, 0, 0, 16384, 16384);
        send_ray(32767, 0, 0, 0, 32767, 0, 1, 65535);
        send_ray(16384, 16384, 16384, 16384, 16384, 16384, 16384, 16384);
        send_ray(-16384, 0, 0, 16384, 0, 0, 65535, 16384);
        send_ray(0, 16384, 0, 0, 16384, 0, 16384, 32768);
        send_ray(9000, 9000, -9000, 0, 0, 16384, 21800, 16384);
        send_ray(-1, -1, -1, -1, -1, -1, 1, 1);

        // wait until all results have drained
        s_valid <= 1'b0;
        while (rays_pending != 0) @(posedge aclk);

        // fill the pipeline against a stalled receiver
        long_hold = 1'b1;
        for (cnt = 0; cnt < 150; cnt++)
            send_ray(unit_comp(), unit_comp(), unit_comp(), unit_comp(), unit_comp(),
                     unit_comp(), index_t'($urandom_range(12000, 40000)),
                     index_t'($urandom_range(12000, 40000)));

        for (cnt = 0; cnt < 1650; cnt++) begin
            if (cnt == 1350)
                calm = 1'b1;
            case ($urandom_range(0, 9))
                0, 1: send_ray(any_comp(), any_comp(), any_comp(), any_comp(), any_comp(),
                               any_comp(), index_t'($urandom), index_t'($urandom));
                2: send_ray(any_comp(), any_comp(), any_comp(), unit_comp(), unit_comp(),
                            unit_comp(), index_t'($urandom), 0);
                default: begin
                    n1 = index_t'($urandom_range(14000, 40000));
                    n2 = index_t'($urandom_range(14000, 40000));
                    send_ray(unit_comp(), unit_comp(), unit_comp(), unit_comp(),
                             unit_comp(), unit_comp(), n1, n2);
                end
            endcase
        end
        s_valid <= 1'b0;

        while (rays_pending != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
